/* rtl/kwm_pkg.sv */
// Shared types and constants for the k-way merge heap.
`timescale 1ns / 1ps
package kwm_pkg;
	localparam int MAX_RUNS = 16;
	localparam int VALUE_W  = 32;
	localparam int RUN_W    = 4;
	localparam int CFG_W    = 5;
	localparam int IDX_W    = $clog2(MAX_RUNS);
	localparam int CNT_W    = IDX_W + 1;
	localparam int CFG_RESET = 2;

	typedef enum logic [1:0] {
		K_LOAD,
		K_LOAD_LAST,
		K_STEP
	} kwm_kind_t;

	typedef struct packed {
		kwm_kind_t                   kind;
		logic [RUN_W-1:0]            run_id;
		logic signed [VALUE_W-1:0]   element;
		logic                        ended;
	} kwm_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [RUN_W-1:0]          run;
	} kwm_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LAST_RD,
		ST_HFY,
		ST_HFY_RD,
		ST_ISSUE_L,
		ST_GET_L,
		ST_GET_R,
		ST_EMIT
	} kwm_state_t;
endpackage

/* rtl/kway_merge_min_heap.sv */
// K-way merge top level: min-heap of run heads, one result per merge step.
// A step item is executed, sifted down one heap level per read-compare pass, then emitted.
// A run-end step adds a read of the last entry before the sift.
// The final loading item also runs the full heapify before its result is emitted.
// Throughput is set by the 1W1R heap memory and its sequencer; a 2-deep request queue hides the front.
// Results are single-cycle strobes; the receiver cannot stall. Reset clears the heap count.
`timescale 1ns / 1ps
module kway_merge_min_heap (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [kwm_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                               start,
	output logic                               busy,
	input  logic [kwm_pkg::RUN_W-1:0]          run_id,
	input  logic signed [kwm_pkg::VALUE_W-1:0] element,
	input  logic                               run_ended,
	output logic                               result_valid,
	output logic signed [kwm_pkg::VALUE_W-1:0] smallest_value,
	output logic [kwm_pkg::RUN_W-1:0]          source_run,
	output logic                               merge_done
);
	logic               q_valid, q_pop;
	kwm_pkg::kwm_item_t q_head;

	kwm_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .start, .busy,
		.run_id, .element, .run_ended, .q_valid, .q_head, .q_pop
	);

	kwm_back u_back (
		.clk, .arst_n, .q_valid, .q_head, .q_pop,
		.result_valid, .smallest_value, .source_run, .merge_done
	);
endmodule

/* rtl/kwm_front.sv */
// Front end: config register, request classification and two-entry request queue.
`timescale 1ns / 1ps
module kwm_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kwm_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                            start,
	output logic                            busy,
	input  logic [kwm_pkg::RUN_W-1:0]       run_id,
	input  logic signed [kwm_pkg::VALUE_W-1:0] element,
	input  logic                            run_ended,
	output logic                            q_valid,
	output kwm_pkg::kwm_item_t              q_head,
	input  logic                            q_pop
);
	logic [kwm_pkg::CFG_W-1:0] run_count_q;
	logic [kwm_pkg::CNT_W-1:0] loaded_q;
	logic [kwm_pkg::CNT_W-1:0] eff;
	kwm_pkg::kwm_item_t        slot_q [2];
	logic                      wr_ptr_q, rd_ptr_q;
	logic [1:0]                fill_q;
	logic                      push;
	kwm_pkg::kwm_item_t        item;

	assign busy    = (fill_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (fill_q != 2'd0);
	assign q_head  = slot_q[rd_ptr_q];

	always_comb begin
		if (int'(run_count_q) >= kwm_pkg::MAX_RUNS) begin
			eff = kwm_pkg::CNT_W'(kwm_pkg::MAX_RUNS);
		end else begin
			eff = kwm_pkg::CNT_W'(run_count_q);
		end
		item.run_id  = run_id;
		item.element = element;
		item.ended   = run_ended;
		if (loaded_q < eff) begin
			item.kind = ((loaded_q + 1'b1) == eff) ? kwm_pkg::K_LOAD_LAST : kwm_pkg::K_LOAD;
		end else begin
			item.kind = kwm_pkg::K_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= kwm_pkg::CFG_W'(kwm_pkg::CFG_RESET);
			loaded_q    <= '0;
			wr_ptr_q    <= 1'b0;
			rd_ptr_q    <= 1'b0;
			fill_q      <= 2'd0;
		end else begin
			if (cfg_we) begin
				run_count_q <= cfg_wdata;
			end
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
				if (item.kind != kwm_pkg::K_STEP) begin
					loaded_q <= loaded_q + 1'b1;
				end
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end
endmodule

/* rtl/kwm_back.sv */
// Back end: heap memory and the load / heapify / sift-down sequencer.
`timescale 1ns / 1ps
module kwm_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  kwm_pkg::kwm_item_t                 q_head,
	output logic                               q_pop,
	output logic                               result_valid,
	output logic signed [kwm_pkg::VALUE_W-1:0] smallest_value,
	output logic [kwm_pkg::RUN_W-1:0]          source_run,
	output logic                               merge_done
);
	kwm_pkg::kwm_state_t state_q, state_d;
	kwm_pkg::kwm_item_t  cur_q;
	kwm_pkg::kwm_entry_t heap_mem [kwm_pkg::MAX_RUNS];
	kwm_pkg::kwm_entry_t rdata_q, top_q, v_q, b_q;
	logic [kwm_pkg::CNT_W-1:0] cnt_q, cnt_inc;
	logic [kwm_pkg::IDX_W-1:0] pos_q, best_q, hfy_i_q;
	logic [kwm_pkg::CNT_W:0]   l_idx, r_idx;
	logic                      hfy_mode_q, r_ok_q;
	logic                      load_wr;
	logic                      mem_we, mem_re;
	logic [kwm_pkg::IDX_W-1:0] mem_wa, mem_ra;
	kwm_pkg::kwm_entry_t       mem_wd;
	logic                      take_l, take_r;

	assign l_idx   = {1'b0, pos_q, 1'b1};
	assign r_idx   = {1'b0, pos_q, 1'b0} + (kwm_pkg::CNT_W+1)'(2);
	assign load_wr = !cur_q.ended && (int'(cnt_q) < kwm_pkg::MAX_RUNS);
	assign cnt_inc = cnt_q + {{(kwm_pkg::CNT_W-1){1'b0}}, load_wr};
	assign take_l  = rdata_q.value < v_q.value;
	assign take_r  = r_ok_q && (rdata_q.value < b_q.value);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kwm_pkg::ST_IDLE: if (q_valid) state_d = kwm_pkg::ST_EXEC;
			kwm_pkg::ST_EXEC: begin
				unique case (cur_q.kind)
					kwm_pkg::K_LOAD:      state_d = kwm_pkg::ST_IDLE;
					kwm_pkg::K_LOAD_LAST: state_d = kwm_pkg::ST_HFY;
					kwm_pkg::K_STEP: begin
						if (cnt_q == '0) state_d = kwm_pkg::ST_EMIT;
						else if (cur_q.ended) state_d = kwm_pkg::ST_LAST_RD;
						else state_d = kwm_pkg::ST_ISSUE_L;
					end
					default: state_d = kwm_pkg::ST_IDLE;
				endcase
			end
			kwm_pkg::ST_LAST_RD: state_d = kwm_pkg::ST_ISSUE_L;
			kwm_pkg::ST_HFY: state_d = (hfy_i_q == '0) ? kwm_pkg::ST_EMIT : kwm_pkg::ST_HFY_RD;
			kwm_pkg::ST_HFY_RD: state_d = kwm_pkg::ST_ISSUE_L;
			kwm_pkg::ST_ISSUE_L: begin
				if (l_idx < {1'b0, cnt_q}) state_d = kwm_pkg::ST_GET_L;
				else state_d = hfy_mode_q ? kwm_pkg::ST_HFY : kwm_pkg::ST_EMIT;
			end
			kwm_pkg::ST_GET_L: state_d = kwm_pkg::ST_GET_R;
			kwm_pkg::ST_GET_R: begin
				if (take_r || best_q != pos_q) state_d = kwm_pkg::ST_ISSUE_L;
				else state_d = hfy_mode_q ? kwm_pkg::ST_HFY : kwm_pkg::ST_EMIT;
			end
			kwm_pkg::ST_EMIT: state_d = kwm_pkg::ST_IDLE;
			default: state_d = kwm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = pos_q;
		mem_ra = pos_q;
		mem_wd = v_q;
		unique case (state_q)
			kwm_pkg::ST_IDLE: q_pop = q_valid;
			kwm_pkg::ST_EXEC: begin
				if (cur_q.kind != kwm_pkg::K_STEP) begin
					mem_we = load_wr;
					mem_wa = cnt_q[kwm_pkg::IDX_W-1:0];
					mem_wd = '{value: cur_q.element, run: cur_q.run_id};
				end else if (cnt_q != '0 && cur_q.ended) begin
					mem_re = 1'b1;
					mem_ra = kwm_pkg::IDX_W'(cnt_q - 1'b1);
				end
			end
			kwm_pkg::ST_HFY: begin
				mem_re = 1'b1;
				mem_ra = hfy_i_q - 1'b1;
			end
			kwm_pkg::ST_ISSUE_L: begin
				if (l_idx < {1'b0, cnt_q}) begin
					mem_re = 1'b1;
					mem_ra = l_idx[kwm_pkg::IDX_W-1:0];
				end else begin
					mem_we = 1'b1;
				end
			end
			kwm_pkg::ST_GET_L: begin
				mem_re = r_idx < {1'b0, cnt_q};
				mem_ra = r_idx[kwm_pkg::IDX_W-1:0];
			end
			kwm_pkg::ST_GET_R: begin
				mem_we = 1'b1;
				if (take_r) mem_wd = rdata_q;
				else if (best_q != pos_q) mem_wd = b_q;
			end
			default: ;
		endcase
	end

	// heap entries live in a 1W1R memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) heap_mem[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= heap_mem[mem_ra];
		if (mem_we && mem_wa == '0) top_q <= mem_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kwm_pkg::ST_IDLE;
			cnt_q        <= '0;
			result_valid <= 1'b0;
			hfy_mode_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= (state_q == kwm_pkg::ST_EMIT);
			unique case (state_q)
				kwm_pkg::ST_EXEC: begin
					if (cur_q.kind != kwm_pkg::K_STEP) begin
						cnt_q <= cnt_inc;
						hfy_mode_q <= 1'b1;
					end else if (cnt_q != '0) begin
						hfy_mode_q <= 1'b0;
						if (cur_q.ended) cnt_q <= cnt_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			kwm_pkg::ST_IDLE: if (q_valid) cur_q <= q_head;
			kwm_pkg::ST_EXEC: begin
				hfy_i_q <= kwm_pkg::IDX_W'(cnt_inc >> 1);
				pos_q   <= '0;
				v_q     <= '{value: cur_q.element, run: top_q.run};
			end
			kwm_pkg::ST_LAST_RD: v_q <= rdata_q;
			kwm_pkg::ST_HFY: begin
				hfy_i_q <= hfy_i_q - 1'b1;
				pos_q   <= hfy_i_q - 1'b1;
			end
			kwm_pkg::ST_HFY_RD: v_q <= rdata_q;
			kwm_pkg::ST_GET_L: begin
				r_ok_q <= r_idx < {1'b0, cnt_q};
				if (take_l) begin
					best_q <= l_idx[kwm_pkg::IDX_W-1:0];
					b_q    <= rdata_q;
				end else begin
					best_q <= pos_q;
					b_q    <= v_q;
				end
			end
			kwm_pkg::ST_GET_R: begin
				// hole moves down to the chosen child
				if (take_r) pos_q <= r_idx[kwm_pkg::IDX_W-1:0];
				else pos_q <= best_q;
			end
			kwm_pkg::ST_EMIT: begin
				merge_done     <= (cnt_q == '0);
				smallest_value <= (cnt_q == '0) ? '0 : top_q.value;
				source_run     <= (cnt_q == '0) ? '0 : top_q.run;
			end
			default: ;
		endcase
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= kwm_pkg::MAX_RUNS) else $error("heap count overflow");
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && merge_done |-> smallest_value == '0 && source_run == '0)
		else $error("done result carries data");
	a_pop_exec: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == kwm_pkg::ST_EXEC) else $error("pop without execute");
	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("back-to-back results");
endmodule

/* tb/tb_kway_merge_min_heap.sv */
// Self-checking testbench for the k-way merge min-heap: queue-fed driver, predictor, strobe monitor.
`timescale 1ns / 1ps
module tb_kway_merge_min_heap;
	typedef struct {
		logic [kwm_pkg::RUN_W-1:0]          rid;
		logic signed [kwm_pkg::VALUE_W-1:0] val;
		logic                               ended;
	} req_t;

	typedef struct {
		logic signed [kwm_pkg::VALUE_W-1:0] val;
		logic [kwm_pkg::RUN_W-1:0]          run;
		logic                               done;
	} merge_out_t;

	localparam int WATCHDOG_LIMIT = 30000;
	localparam int SETTLE_CYCLES  = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [kwm_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic [kwm_pkg::RUN_W-1:0] run_id = '0;
	logic signed [kwm_pkg::VALUE_W-1:0] element = '0;
	logic run_ended = 1'b0;
	logic result_valid;
	logic signed [kwm_pkg::VALUE_W-1:0] smallest_value;
	logic [kwm_pkg::RUN_W-1:0] source_run;
	logic merge_done;

	kway_merge_min_heap dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .run_id(run_id), .element(element),
		.run_ended(run_ended), .result_valid(result_valid),
		.smallest_value(smallest_value), .source_run(source_run), .merge_done(merge_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic signed [kwm_pkg::VALUE_W-1:0] hv [kwm_pkg::MAX_RUNS];
	logic [kwm_pkg::RUN_W-1:0]          hr [kwm_pkg::MAX_RUNS];
	int heap_cnt = 0;
	int load_cnt = 0;
	int run_cfg  = kwm_pkg::CFG_RESET;

	req_t       pending [$];
	merge_out_t expected_outs [$];
	req_t       cur_req;
	int n_pushed = 0, n_acc = 0, n_results = 0, n_done = 0, errors = 0, idle_cycles = 0;
	int burst_left = 0, gap_left = 0;

	task automatic sift_down(input int pos);
		int l, r, best;
		logic signed [kwm_pkg::VALUE_W-1:0] tv;
		logic [kwm_pkg::RUN_W-1:0] tr;
		forever begin
			l = 2 * pos + 1;
			r = 2 * pos + 2;
			best = pos;
			if (l < heap_cnt && hv[l] < hv[best]) best = l;
			if (r < heap_cnt && hv[r] < hv[best]) best = r;
			if (best == pos) return;
			tv = hv[pos]; hv[pos] = hv[best]; hv[best] = tv;
			tr = hr[pos]; hr[pos] = hr[best]; hr[best] = tr;
			pos = best;
		end
	endtask

	task automatic push_head();
		merge_out_t o;
		if (heap_cnt == 0) begin
			o.val = '0; o.run = '0; o.done = 1'b1;
		end else begin
			o.val = hv[0]; o.run = hr[0]; o.done = 1'b0;
		end
		expected_outs.push_back(o);
	endtask

	task automatic predict_merge(input req_t q);
		int eff, i;
		eff = (run_cfg > kwm_pkg::MAX_RUNS) ? kwm_pkg::MAX_RUNS : run_cfg;
		if (load_cnt < eff) begin
			load_cnt++;
			if (!q.ended && heap_cnt < kwm_pkg::MAX_RUNS) begin
				hv[heap_cnt] = q.val;
				hr[heap_cnt] = q.rid;
				heap_cnt++;
			end
			if (load_cnt < eff) return;
			if (heap_cnt >= 2) begin
				i = heap_cnt / 2;
				while (i > 0) begin
					i--;
					sift_down(i);
				end
			end
			push_head();
			return;
		end
		if (heap_cnt > 0) begin
			if (q.ended) begin
				heap_cnt--;
				hv[0] = hv[heap_cnt];
				hr[0] = hr[heap_cnt];
			end else begin
				hv[0] = q.val;
			end
			sift_down(0);
		end
		push_head();
	endtask

	// driver: bursts with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_merge(cur_req);
				n_acc++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending.size() > 0) begin
					cur_req <= pending[0];
					run_id <= pending[0].rid;
					element <= pending[0].val;
					run_ended <= pending[0].ended;
					void'(pending.pop_front());
					start <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 10);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		merge_out_t e;
		if (arst_n && result_valid) begin
			n_results++;
			if (merge_done) n_done++;
			if (expected_outs.size() == 0) begin
				$display("%0t: unexpected result value=%0d run=%0d done=%0b",
					$time, smallest_value, source_run, merge_done);
				errors++;
			end else begin
				e = expected_outs.pop_front();
				if (smallest_value !== e.val || source_run !== e.run || merge_done !== e.done) begin
					$display("%0t: mismatch expected value=%0d run=%0d done=%0b actual value=%0d run=%0d done=%0b",
						$time, e.val, e.run, e.done, smallest_value, source_run, merge_done);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no request or result
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send(input logic [kwm_pkg::RUN_W-1:0] rid,
			input logic signed [kwm_pkg::VALUE_W-1:0] val, input logic ended);
		req_t q;
		q.rid = rid; q.val = val; q.ended = ended;
		pending.push_back(q);
		n_pushed++;
	endtask

	task automatic wait_accepted();
		while (n_acc != n_pushed) @(posedge clk);
	endtask

	task automatic drain_and_write(input int v);
		wait_accepted();
		while (expected_outs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[kwm_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		run_cfg = v;
	endtask

	// one step: next element of the run on top, mostly ascending
	task automatic step_random(input int end_odds);
		longint nv;
		logic [kwm_pkg::RUN_W-1:0] rid;
		logic signed [kwm_pkg::VALUE_W-1:0] v;
		wait_accepted();
		rid = (heap_cnt > 0) ? hr[0] : kwm_pkg::RUN_W'($urandom);
		if ($urandom_range(0, 14) == 0) rid = kwm_pkg::RUN_W'($urandom);
		case ($urandom_range(0, 19))
			0: v = {1'b0, {(kwm_pkg::VALUE_W-1){1'b1}}};
			1: v = {1'b1, {(kwm_pkg::VALUE_W-1){1'b0}}};
			2, 3: v = $urandom;
			default: begin
				nv = (heap_cnt > 0) ? longint'(hv[0]) : 0;
				nv = nv + $urandom_range(0, 60);
				if (nv > 64'sd2147483647) nv = 64'sd2147483647;
				v = nv[kwm_pkg::VALUE_W-1:0];
			end
		endcase
		send(rid, v, $urandom_range(1, end_odds) == 1);
	endtask

	task automatic load_random(input int n);
		repeat (n) begin
			send(kwm_pkg::RUN_W'($urandom),
				($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200)) - 100,
				$urandom_range(0, 5) == 0);
		end
	endtask

	task automatic merge_out(input int end_odds);
		int guard;
		guard = 0;
		wait_accepted();
		while (heap_cnt > 0 && guard < 800) begin
			step_random(end_odds);
			guard++;
		end
		repeat (2) step_random(2);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count zero: every request answers done
		drain_and_write(0);
		send(4'hf, 32'sd5, 1'b0);
		send(4'h0, -32'sd5, 1'b1);
		send(4'ha, 32'sd0, 1'b0);

		// single run flagged empty at load
		drain_and_write(1);
		send(4'h3, 32'sd7, 1'b1);
		send(4'h3, 32'sd7, 1'b0);

		// two runs at the value extremes, ties, wrong run
		drain_and_write(3);
		send(4'hf, 32'sh7fffffff, 1'b0);
		send(4'h0, 32'sh80000000, 1'b0);
		wait_accepted();
		send(4'h0, 32'sh80000000, 1'b0);
		send(4'h0, 32'sh7fffffff, 1'b0);
		wait_accepted();
		send(4'h5, 32'sh7fffffff, 1'b0);
		wait_accepted();
		send(hr[0], 32'sh7fffffff, 1'b1);
		wait_accepted();
		send(hr[0], 32'sd0, 1'b1);
		send(4'h9, 32'sd1, 1'b0);

		// four more runs, one empty, tied heads
		drain_and_write(7);
		send(4'h1, 32'sd10, 1'b0);
		send(4'h2, 32'sd10, 1'b0);
		send(4'h3, 32'sd0, 1'b1);
		send(4'hc, -32'sd3, 1'b0);
		merge_out(60);

		// above the maximum: saturates, loads the remaining nine
		drain_and_write(31);
		load_random(9);
		merge_out(65);

		drain_and_write(kwm_pkg::MAX_RUNS);
		repeat (10) step_random(2);

		wait_accepted();
		while (expected_outs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d requests over run counts 0..31, %0d results (%0d done).",
			n_acc, n_results, n_done);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

/* sim.f */
rtl/kwm_pkg.sv
rtl/kwm_front.sv
rtl/kwm_back.sv
rtl/kway_merge_min_heap.sv
tb/tb_kway_merge_min_heap.sv
